// File: sv/ppa_pkg.sv
`timescale 1ns / 1ps
// ppa_pkg: shared types and constants for the pixel point adjust block
// payload structs, operation and register codes, contrast scaling constants
// no dependencies

package ppa_pkg;

    // operation codes; 6 and 7 pass the pixel unchanged
    typedef enum logic [2:0] {
        OP_INVERT     = 3'd0,
        OP_GREY_AVG   = 3'd1,
        OP_GREY_WGT   = 3'd2,
        OP_BRIGHTNESS = 3'd3,
        OP_CONTRAST   = 3'd4,
        OP_SWAP_RB    = 3'd5
    } op_t;

    // register index, byte address is 4 * index
    typedef enum logic [2:0] {
        REG_OPERATION     = 3'd0,
        REG_INVERT_SELECT = 3'd1,
        REG_FOUR_CHANNELS = 3'd2,
        REG_RED_WEIGHT    = 3'd3,
        REG_GREEN_WEIGHT  = 3'd4,
        REG_BLUE_WEIGHT   = 3'd5,
        REG_AMOUNT        = 3'd6
    } reg_idx_t;

    localparam int AddrW = 5;
    localparam int DataW = 32;

    // floor(n / 20000) as (n * ContrastRecip) >> RecipShift, exact for n < 2**24
    localparam int RecipShift = 39;
    localparam int ScaleW     = 41;
    localparam logic [24:0] ContrastRecip = 25'd27487791;
    // 2550000 * ContrastRecip
    localparam logic [46:0] ContrastBias  = 47'd70093867050000;
    localparam logic [15:0] ContrastKReset = 16'd10000;
    localparam logic signed [8:0] ContrastAmtMax = 9'sd100;
    localparam logic signed [8:0] ContrastAmtMin = -9'sd100;

    // floor(x / 3) as (x * 683) >> 11 for x < 1024
    localparam logic [9:0] ThirdRecip = 10'd683;
    localparam int ThirdShift = 11;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
        logic       last_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic       last_out;
    } pixel_out_t;

    typedef struct packed {
        op_t                operation;
        logic [1:0]         invert_select;
        logic               four_channels;
        logic [9:0]         red_weight;
        logic [9:0]         green_weight;
        logic [9:0]         blue_weight;
        logic signed [8:0]  amount;
        logic [ScaleW-1:0]  contrast_scale;
    } ppa_cfg_t;

endpackage

// File: sv/ppa_regs.sv
`timescale 1ns / 1ps
// ppa_regs: APB register file for the pixel point adjust block
// also holds the contrast scale derived from the amount register
// depends on ppa_pkg

module ppa_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ppa_pkg::AddrW-1:0]   paddr,
    input  logic [ppa_pkg::DataW-1:0]   pwdata,
    output logic [ppa_pkg::DataW-1:0]   prdata,
    output logic                        pready,
    output ppa_pkg::ppa_cfg_t           cfg
);

    ppa_pkg::op_t               operation_reg;
    logic [1:0]                 invert_select_reg;
    logic                       four_channels_reg;
    logic [9:0]                 red_weight_reg;
    logic [9:0]                 green_weight_reg;
    logic [9:0]                 blue_weight_reg;
    logic signed [8:0]          amount_reg;
    logic [15:0]                amt_sq_reg;
    logic [ppa_pkg::ScaleW-1:0] contrast_scale_reg;

    ppa_pkg::reg_idx_t          reg_idx;
    logic                       wr_access;
    logic                       wr_setup_amount;
    logic signed [8:0]          amt_wr;
    logic signed [8:0]          amt_clamped;
    logic signed [8:0]          amt_base;
    logic [15:0]                amt_sq_next;
    logic [ppa_pkg::ScaleW-1:0] contrast_scale_next;

    assign reg_idx   = ppa_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_access = psel && penable && pwrite;
    assign pready    = 1'b1;

    // (100 + a)^2 is taken in the setup cycle, the scale multiply in the access cycle
    assign wr_setup_amount = psel && !penable && pwrite && (reg_idx == ppa_pkg::REG_AMOUNT);
    assign amt_wr          = $signed(pwdata[8:0]);

    always_comb
    begin
        priority if (amt_wr > ppa_pkg::ContrastAmtMax)
            amt_clamped = ppa_pkg::ContrastAmtMax;
        else if (amt_wr < ppa_pkg::ContrastAmtMin)
            amt_clamped = ppa_pkg::ContrastAmtMin;
        else
            amt_clamped = amt_wr;
    end

    assign amt_base            = amt_clamped + 9'sd100;
    assign amt_sq_next         = amt_base[7:0] * amt_base[7:0];
    assign contrast_scale_next = amt_sq_reg * ppa_pkg::ContrastRecip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amt_sq_reg <= ppa_pkg::ContrastKReset;
        end
        else if (wr_setup_amount)
        begin
            amt_sq_reg <= amt_sq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operation_reg      <= ppa_pkg::OP_INVERT;
            invert_select_reg  <= 2'd1;
            four_channels_reg  <= 1'b1;
            red_weight_reg     <= 10'd77;
            green_weight_reg   <= 10'd150;
            blue_weight_reg    <= 10'd29;
            amount_reg         <= 9'sd0;
            contrast_scale_reg <= ppa_pkg::ScaleW'(ppa_pkg::ContrastKReset)
                                  * ppa_pkg::ContrastRecip;
        end
        else if (wr_access)
        begin
            unique case (reg_idx)
                ppa_pkg::REG_OPERATION:
                    operation_reg <= ppa_pkg::op_t'(pwdata[2:0]);
                ppa_pkg::REG_INVERT_SELECT:
                    invert_select_reg <= pwdata[1:0];
                ppa_pkg::REG_FOUR_CHANNELS:
                    four_channels_reg <= pwdata[0];
                ppa_pkg::REG_RED_WEIGHT:
                    red_weight_reg <= pwdata[9:0];
                ppa_pkg::REG_GREEN_WEIGHT:
                    green_weight_reg <= pwdata[9:0];
                ppa_pkg::REG_BLUE_WEIGHT:
                    blue_weight_reg <= pwdata[9:0];
                ppa_pkg::REG_AMOUNT:
                begin
                    amount_reg         <= $signed(pwdata[8:0]);
                    contrast_scale_reg <= contrast_scale_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ppa_pkg::REG_OPERATION:     prdata = {29'd0, operation_reg};
            ppa_pkg::REG_INVERT_SELECT: prdata = {30'd0, invert_select_reg};
            ppa_pkg::REG_FOUR_CHANNELS: prdata = {31'd0, four_channels_reg};
            ppa_pkg::REG_RED_WEIGHT:    prdata = {22'd0, red_weight_reg};
            ppa_pkg::REG_GREEN_WEIGHT:  prdata = {22'd0, green_weight_reg};
            ppa_pkg::REG_BLUE_WEIGHT:   prdata = {22'd0, blue_weight_reg};
            ppa_pkg::REG_AMOUNT:        prdata = {23'd0, amount_reg};
            default:                    prdata = '0;
        endcase
    end

    assign cfg.operation      = operation_reg;
    assign cfg.invert_select  = invert_select_reg;
    assign cfg.four_channels  = four_channels_reg;
    assign cfg.red_weight     = red_weight_reg;
    assign cfg.green_weight   = green_weight_reg;
    assign cfg.blue_weight    = blue_weight_reg;
    assign cfg.amount         = amount_reg;
    assign cfg.contrast_scale = contrast_scale_reg;

endmodule

// File: sv/ppa_calc.sv
`timescale 1ns / 1ps
// ppa_calc: combinational pixel adjustment between the input and result registers
// depends on ppa_pkg

module ppa_calc
(
    input  ppa_pkg::ppa_cfg_t  cfg,
    input  ppa_pkg::pixel_in_t pix,
    output ppa_pkg::pixel_out_t res
);

    function automatic logic [7:0] bright_ch(input logic [7:0] p,
                                             input logic signed [8:0] amt);
        logic signed [9:0] sum;
        begin
            sum = $signed({2'b00, p}) + 10'(amt);
            if (sum[9])
                bright_ch = 8'd0;
            else if (sum[8])
                bright_ch = 8'd255;
            else
                bright_ch = sum[7:0];
        end
    endfunction

    // n = (2p - 255) * k + 2550000, result floor(n / 20000) clamped
    function automatic logic [7:0] contrast_ch(input logic [7:0] p,
                                               input logic [ppa_pkg::ScaleW-1:0] scale);
        logic signed [10:0] dev;
        logic signed [41:0] sc;
        logic signed [52:0] prod;
        logic signed [52:0] acc;
        begin
            dev  = $signed({2'b00, p, 1'b0}) - 11'sd255;
            sc   = $signed({1'b0, scale});
            prod = dev * sc;
            acc  = prod + $signed({6'd0, ppa_pkg::ContrastBias});
            if (acc[52])
                contrast_ch = 8'd0;
            else if (|acc[51:47])
                contrast_ch = 8'd255;
            else
                contrast_ch = acc[46:39];
        end
    endfunction

    logic [9:0]  avg_sum;
    logic [18:0] avg_prod;
    logic [7:0]  avg_grey;
    logic [19:0] wgt_sum;
    logic [7:0]  wgt_grey;
    logic [7:0]  inv_mask;

    assign avg_sum  = 10'(pix.red_in) + 10'(pix.green_in) + 10'(pix.blue_in);
    assign avg_prod = avg_sum * ppa_pkg::ThirdRecip;
    assign avg_grey = avg_prod[ppa_pkg::ThirdShift +: 8];

    assign wgt_sum  = 20'(pix.red_in) * 20'(cfg.red_weight)
                    + 20'(pix.green_in) * 20'(cfg.green_weight)
                    + 20'(pix.blue_in) * 20'(cfg.blue_weight);
    assign wgt_grey = (|wgt_sum[19:16]) ? 8'd255 : wgt_sum[15:8];

    assign inv_mask = {8{cfg.invert_select[0]}};

    always_comb
    begin
        res.red_out   = pix.red_in;
        res.green_out = pix.green_in;
        res.blue_out  = pix.blue_in;
        res.alpha_out = pix.alpha_in;
        res.last_out  = pix.last_in;
        unique case (cfg.operation)
            ppa_pkg::OP_INVERT:
            begin
                res.red_out   = pix.red_in ^ inv_mask;
                res.green_out = pix.green_in ^ inv_mask;
                res.blue_out  = pix.blue_in ^ inv_mask;
                if (cfg.invert_select[1] && cfg.four_channels)
                    res.alpha_out = ~pix.alpha_in;
            end
            ppa_pkg::OP_GREY_AVG:
            begin
                res.red_out   = avg_grey;
                res.green_out = avg_grey;
                res.blue_out  = avg_grey;
            end
            ppa_pkg::OP_GREY_WGT:
            begin
                res.red_out   = wgt_grey;
                res.green_out = wgt_grey;
                res.blue_out  = wgt_grey;
            end
            ppa_pkg::OP_BRIGHTNESS:
            begin
                res.red_out   = bright_ch(pix.red_in, cfg.amount);
                res.green_out = bright_ch(pix.green_in, cfg.amount);
                res.blue_out  = bright_ch(pix.blue_in, cfg.amount);
            end
            ppa_pkg::OP_CONTRAST:
            begin
                res.red_out   = contrast_ch(pix.red_in, cfg.contrast_scale);
                res.green_out = contrast_ch(pix.green_in, cfg.contrast_scale);
                res.blue_out  = contrast_ch(pix.blue_in, cfg.contrast_scale);
            end
            ppa_pkg::OP_SWAP_RB:
            begin
                res.red_out  = pix.blue_in;
                res.blue_out = pix.red_in;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: sv/pixel_point_adjust_core.sv
`timescale 1ns / 1ps
// pixel_point_adjust_core: one RGBA pixel in, one adjusted pixel out
// depends on ppa_pkg, ppa_regs, ppa_calc
//
// usage:
//   pixel channel: pixel_valid / pixel_stall / pixel carry one pixel per transfer
//   result channel: result_valid / result_stall / result carry the adjusted pixel
//   the receiver raises result_stall to hold a result; the held result stays put
//   APB port selects the operation and its settings; write it only between images
// path: an accepted pixel is held in the input register; its adjusted value is
//   loaded into the result register when that register is empty or draining
// throughput: one pixel per cycle with result_stall low; the input register
//   refills while the result register drains, so pixel_stall rises only when
//   the result register is full and stalled and the input register is also full
// contrast scale is formed during the amount write (square in the setup
//   cycle, reciprocal multiply in the access cycle)
// reset: both pipeline registers empty, registers at their documented defaults
//   (invert colour channels, weights 77/150/29, amount 0)

module pixel_point_adjust_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pixel_valid,
    output logic                        pixel_stall,
    input  ppa_pkg::pixel_in_t          pixel,
    output logic                        result_valid,
    input  logic                        result_stall,
    output ppa_pkg::pixel_out_t         result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ppa_pkg::AddrW-1:0]   paddr,
    input  logic [ppa_pkg::DataW-1:0]   pwdata,
    output logic [ppa_pkg::DataW-1:0]   prdata,
    output logic                        pready
);

    ppa_pkg::ppa_cfg_t   cfg;
    ppa_pkg::pixel_in_t  pix_reg;
    ppa_pkg::pixel_out_t res_reg;
    ppa_pkg::pixel_out_t calc_out;
    logic                pix_valid_reg;
    logic                pix_valid_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    logic                pix_load;
    logic                res_load;

    ppa_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ppa_calc u_calc
    (
        .cfg (cfg),
        .pix (pix_reg),
        .res (calc_out)
    );

    // result register takes a new value when empty or being drained
    assign res_load    = !res_valid_reg || !result_stall;
    assign pixel_stall = pix_valid_reg && !res_load;
    assign pix_load    = pixel_valid && !pixel_stall;

    assign pix_valid_next = pix_load ? 1'b1 : (res_load ? 1'b0 : pix_valid_reg);
    assign res_valid_next = res_load ? pix_valid_reg : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_load)
            pix_reg <= pixel;
        if (res_load && pix_valid_reg)
            res_reg <= calc_out;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
